// ----- hdl/round_robin_run_queue_top_defines.svh -----
// Assertion macros shared by the run queue RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ROUND_ROBIN_RUN_QUEUE_TOP_DEFINES_SVH
`define ROUND_ROBIN_RUN_QUEUE_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// property must hold at every rising clock edge outside reset
`define RRQ_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("run queue assertion failed");
// condition must never be true outside reset
`define RRQ_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("run queue forbidden condition seen");
`else
`define RRQ_ASSERT(label, clk, rst_n, prop)
`define RRQ_ASSERT_NEVER(label, clk, rst_n, cond)
`endif

`endif

// ----- hdl/rrq_pkg.sv -----
// Shared constants, operation codes and command struct for the run queue.
// No dependencies.
package rrq_pkg;

    localparam int NUM_IDS_DEFAULT = 64;
    localparam int ID_W            = 6;
    localparam int KIND_W          = 2;
    localparam int QLEN_W          = 7;

    localparam logic [KIND_W-1:0] KIND_ENQUEUE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DEQUEUE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DETACH  = 2'd2;

    typedef struct packed {
        logic load;
        logic commit;
    } rrq_cmd_t;

endpackage

// ----- hdl/rrq_ctrl.sv -----
// Run queue controller: request/response handshake and operation sequencing.
// Depends on rrq_pkg.
module rrq_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    output rrq_pkg::rrq_cmd_t cmd
);

    typedef enum logic
    {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;

    assign req_ready  = (state_reg == ST_IDLE);
    assign rsp_valid  = rsp_valid_reg;
    assign cmd.load   = req_valid && (state_reg == ST_IDLE);
    assign cmd.commit = (state_reg == ST_EXEC) && (!rsp_valid_reg || rsp_ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.load)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (cmd.commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        rsp_valid_next = rsp_valid_reg;
        if (cmd.commit)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

// ----- hdl/rrq_datapath.sv -----
// Run queue datapath: link memories, membership mask, head/tail/count, result register.
// Depends on rrq_pkg and round_robin_run_queue_top_defines.svh.
`include "round_robin_run_queue_top_defines.svh"

module rrq_datapath
#(
    parameter int NUM_IDS = rrq_pkg::NUM_IDS_DEFAULT
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  rrq_pkg::rrq_cmd_t          cmd,
    input  logic [rrq_pkg::KIND_W-1:0] kind,
    input  logic [rrq_pkg::ID_W-1:0]   vcpu_id,
    output logic                       status,
    output logic                       out_valid,
    output logic [rrq_pkg::ID_W-1:0]   out_id,
    output logic [rrq_pkg::QLEN_W-1:0] queue_length
);

    localparam int IW = $clog2(NUM_IDS);
    localparam int CW = $clog2(NUM_IDS + 1);

    logic [IW-1:0] next_mem [NUM_IDS];
    logic [IW-1:0] prev_mem [NUM_IDS];

    logic [rrq_pkg::KIND_W-1:0] op_kind_reg;
    logic [IW-1:0]              tgt_reg;
    logic                       in_range_reg;
    logic [IW-1:0]              nx_rd_reg;
    logic [IW-1:0]              pv_rd_reg;

    logic [IW-1:0]      head_reg, head_next;
    logic [IW-1:0]      tail_reg, tail_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [NUM_IDS-1:0] mask_reg, mask_next;

    logic                        status_reg, status_next;
    logic                        out_valid_reg, out_valid_next;
    logic [rrq_pkg::ID_W-1:0]    out_id_reg, out_id_next;
    logic [rrq_pkg::QLEN_W-1:0]  qlen_reg;

    logic [IW+rrq_pkg::ID_W-1:0]   id_ext;
    logic [IW+rrq_pkg::ID_W-1:0]   head_ext;
    logic [CW+rrq_pkg::QLEN_W-1:0] count_ext;
    logic [IW-1:0]                 rd_addr;
    logic                          in_range;
    logic                          mask_hit;
    logic                          do_unlink;

    logic          nx_we, pv_we;
    logic [IW-1:0] nx_waddr, nx_wdata;
    logic [IW-1:0] pv_waddr, pv_wdata;

    assign id_ext    = {{IW{1'b0}}, vcpu_id};
    assign head_ext  = {{rrq_pkg::ID_W{1'b0}}, head_reg};
    assign count_ext = {{rrq_pkg::QLEN_W{1'b0}}, count_next};
    assign in_range  = ({26'd0, vcpu_id} < 32'(NUM_IDS));
    assign rd_addr   = (kind == rrq_pkg::KIND_DEQUEUE) ? head_reg : id_ext[IW-1:0];
    assign mask_hit  = in_range_reg && mask_reg[tgt_reg];

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_kind_reg  <= kind;
            tgt_reg      <= rd_addr;
            in_range_reg <= in_range;
            nx_rd_reg    <= next_mem[rd_addr];
            pv_rd_reg    <= prev_mem[rd_addr];
        end
        if (nx_we)
        begin
            next_mem[nx_waddr] <= nx_wdata;
        end
        if (pv_we)
        begin
            prev_mem[pv_waddr] <= pv_wdata;
        end
    end

    always_comb
    begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        mask_next      = mask_reg;
        status_next    = 1'b1;
        out_valid_next = 1'b0;
        out_id_next    = '0;
        do_unlink      = 1'b0;
        nx_we          = 1'b0;
        nx_waddr       = tail_reg;
        nx_wdata       = tgt_reg;
        pv_we          = 1'b0;
        pv_waddr       = tgt_reg;
        pv_wdata       = tail_reg;

        case (op_kind_reg)
            rrq_pkg::KIND_ENQUEUE:
            begin
                if (in_range_reg && !mask_hit)
                begin
                    if (count_reg == '0)
                    begin
                        head_next = tgt_reg;
                    end
                    else
                    begin
                        nx_we = 1'b1;
                        pv_we = 1'b1;
                    end
                    tail_next          = tgt_reg;
                    mask_next[tgt_reg] = 1'b1;
                    count_next         = count_reg + CW'(1);
                    status_next        = 1'b0;
                end
            end
            rrq_pkg::KIND_DEQUEUE:
            begin
                if (count_reg != '0)
                begin
                    do_unlink      = 1'b1;
                    out_valid_next = 1'b1;
                    out_id_next    = head_ext[rrq_pkg::ID_W-1:0];
                    status_next    = 1'b0;
                end
            end
            rrq_pkg::KIND_DETACH:
            begin
                if (mask_hit)
                begin
                    do_unlink   = 1'b1;
                    status_next = 1'b0;
                end
            end
            default:
            begin
                status_next = 1'b1;
            end
        endcase

        if (do_unlink)
        begin
            if (count_reg <= CW'(1))
            begin
                head_next = '0;
                tail_next = '0;
            end
            else
            begin
                if (tgt_reg == head_reg)
                begin
                    head_next = nx_rd_reg;
                end
                else
                begin
                    nx_we    = 1'b1;
                    nx_waddr = pv_rd_reg;
                    nx_wdata = nx_rd_reg;
                end
                if (tgt_reg == tail_reg)
                begin
                    tail_next = pv_rd_reg;
                end
                else
                begin
                    pv_we    = 1'b1;
                    pv_waddr = nx_rd_reg;
                    pv_wdata = pv_rd_reg;
                end
            end
            mask_next[tgt_reg] = 1'b0;
            count_next         = count_reg - CW'(1);
        end

        if (!cmd.commit)
        begin
            nx_we = 1'b0;
            pv_we = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            mask_reg  <= '0;
        end
        else if (cmd.commit)
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            mask_reg  <= mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            status_reg    <= status_next;
            out_valid_reg <= out_valid_next;
            out_id_reg    <= out_id_next;
            qlen_reg      <= count_ext[rrq_pkg::QLEN_W-1:0];
        end
    end

    assign status       = status_reg;
    assign out_valid    = out_valid_reg;
    assign out_id       = out_id_reg;
    assign queue_length = qlen_reg;

    `RRQ_ASSERT(a_mask_matches_count, clk, rst_n, $countones(mask_reg) == int'(count_reg))
    `RRQ_ASSERT(a_dequeue_clears_member, clk, rst_n, (cmd.commit && (op_kind_reg == rrq_pkg::KIND_DEQUEUE) && (count_reg != '0)) |=> !mask_reg[$past(head_reg)])
    `RRQ_ASSERT_NEVER(a_count_bound, clk, rst_n, count_reg > CW'(NUM_IDS))

endmodule

// ----- hdl/round_robin_run_queue_top.sv -----
// Round-robin run queue of virtual CPU ids: controller plus datapath.
// Depends on rrq_pkg, rrq_ctrl and rrq_datapath.
//
// Usage:
//   Request channel (req_valid/req_ready) carries kind and vcpu_id: enqueue at
//   tail, dequeue head, or detach a given id. Response channel
//   (rsp_valid/rsp_ready) returns one result per request: status, out_valid,
//   out_id and the queue length after the operation.
//   When a request is taken, both link memories are read at the head or the
//   given id; the following ST_EXEC state writes back at most one entry per
//   link memory and updates head, tail, count and the membership mask. The
//   response is valid from the clock edge that performs that write-back on.
//   A new request is accepted only once the previous one has written back,
//   as set by the read then write-back of the single-port link memories.
//   A finished response sits in the output register while a new request is
//   accepted; if rsp_ready stays low, that request waits in ST_EXEC and
//   req_ready stays low until the response register frees up.
//   Reset empties the queue (mask, head, tail, count cleared); link memories
//   are not cleared since their entries are only used for queued ids.
module round_robin_run_queue_top
#(
    parameter int NUM_IDS = rrq_pkg::NUM_IDS_DEFAULT
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    output logic                       req_ready,
    input  logic [rrq_pkg::KIND_W-1:0] kind,
    input  logic [rrq_pkg::ID_W-1:0]   vcpu_id,
    output logic                       rsp_valid,
    input  logic                       rsp_ready,
    output logic                       status,
    output logic                       out_valid,
    output logic [rrq_pkg::ID_W-1:0]   out_id,
    output logic [rrq_pkg::QLEN_W-1:0] queue_length
);

    rrq_pkg::rrq_cmd_t cmd;

    rrq_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .cmd       (cmd)
    );

    rrq_datapath
    #(
        .NUM_IDS (NUM_IDS)
    )
    u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .kind         (kind),
        .vcpu_id      (vcpu_id),
        .status       (status),
        .out_valid    (out_valid),
        .out_id       (out_id),
        .queue_length (queue_length)
    );

endmodule
